>>> rtl/bda_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; used by the interfaces, controller, datapath, top level and checker.
package bda_pkg;

  localparam int unsigned ValueW = 16;
  localparam int unsigned AsciiW = 6;

  typedef logic [ValueW-1:0] value_t;
  typedef logic [AsciiW-1:0] ascii_t;
  typedef logic [2:0]        pos_t;
  typedef logic [3:0]        digit_t;

  // digit positions: 0 = ten-thousands ... 4 = ones
  localparam pos_t   POS_WIDE_FIRST   = 3'd0;
  localparam pos_t   POS_NARROW_FIRST = 3'd2;
  localparam pos_t   POS_ONES         = 3'd4;
  localparam ascii_t ASCII_ZERO       = 6'd48;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture a new request
    logic sub;    // subtract current power of ten, bump digit
    logic emit;   // write digit to output register, move to next position
    logic skip;   // drop a leading zero, move to next position
  } bda_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ge;           // remainder still >= current power of ten
    logic emit_needed;  // digit is shown (nonzero, after first shown, or ones)
    logic is_ones;
  } bda_status_t;

  function automatic value_t pow_step(input pos_t pos);
    value_t step;
    case (pos)
      3'd0:    step = 16'd10000;
      3'd1:    step = 16'd1000;
      3'd2:    step = 16'd100;
      3'd3:    step = 16'd10;
      default: step = 16'd1;
    endcase
    return step;
  endfunction

endpackage

>>> rtl/bda_if.sv
// Valid/ready channel interfaces for the converter's request and result sides.
// Depends on bda_pkg for payload types.
interface bda_in_if;
  logic              valid;
  logic              ready;
  bda_pkg::value_t   value;
  logic              wide_mode;

  modport source (output valid, output value, output wide_mode, input ready);
  modport sink   (input valid, input value, input wide_mode, output ready);
endinterface

interface bda_out_if;
  logic              valid;
  logic              ready;
  bda_pkg::ascii_t   ascii_digit;
  logic              last_digit;

  modport source (output valid, output ascii_digit, output last_digit, input ready);
  modport sink   (input valid, input ascii_digit, input last_digit, output ready);
endinterface

>>> rtl/bda_ctrl.sv
// Controller for the converter: sequences subtraction, emit and skip steps.
// Depends on bda_pkg; drives bda_dp through bda_cmd_t, reads bda_status_t.
module bda_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bda_pkg::bda_status_t status,
  output bda_pkg::bda_cmd_t    cmd
);
  import bda_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.ge) begin
          cmd.sub = 1'b1;
        end else if (!status.emit_needed) begin
          cmd.skip = 1'b1;
        end else if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (status.is_ones) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/bda_dp.sv
// Datapath for the converter: remainder, digit counter, position and output register.
// Depends on bda_pkg (pow_step table, command and status structs).
module bda_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bda_pkg::value_t      value,
  input  logic                 wide_mode,
  input  bda_pkg::bda_cmd_t    cmd,
  output bda_pkg::bda_status_t status,
  output bda_pkg::ascii_t      ascii_digit,
  output logic                 last_digit
);
  import bda_pkg::*;

  value_t rem_r;
  digit_t digit_r;
  pos_t   pos_r;
  logic   started_r;
  ascii_t ascii_r;
  logic   last_r;
  value_t step;

  assign step               = pow_step(pos_r);
  assign status.ge          = (rem_r >= step);
  assign status.is_ones     = (pos_r == POS_ONES);
  assign status.emit_needed = (digit_r != '0) || started_r || status.is_ones;

  assign ascii_digit = ascii_r;
  assign last_digit  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else if (cmd.load) begin
      started_r <= 1'b0;
    end else if (cmd.emit) begin
      started_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r   <= wide_mode ? value : {8'd0, value[7:0]};
      pos_r   <= wide_mode ? POS_WIDE_FIRST : POS_NARROW_FIRST;
      digit_r <= '0;
    end else if (cmd.sub) begin
      rem_r   <= rem_r - step;
      digit_r <= digit_r + 4'd1;
    end else if (cmd.emit || cmd.skip) begin
      pos_r   <= pos_r + 3'd1;
      digit_r <= '0;
    end
    if (cmd.emit) begin
      ascii_r <= ASCII_ZERO + {2'b00, digit_r};
      last_r  <= status.is_ones;
    end
  end

endmodule

>>> rtl/binary_to_decimal_ascii.sv
// Channel    | Dir | Payload                        | Handshake
// in_chan    | in  | value[15:0], wide_mode         | valid/ready
// out_chan   | out | ascii_digit[5:0], last_digit   | valid/ready
//
// One request at a time. Each digit is found by repeated subtraction of its power
// of ten, one subtraction per unit of its value, and is then emitted or skipped.
// Narrow mode converts the low byte over three positions, wide mode over five.
// The output register lets the next request in while the last digit waits.
// Reset (rst_n low, synchronous) empties the controller and output valid.
// A stalled output holds the datapath before emitting the next digit.
module binary_to_decimal_ascii (
  input  logic       clk,
  input  logic       rst_n,
  bda_in_if.sink     in_chan,
  bda_out_if.source  out_chan
);
  import bda_pkg::*;

  bda_cmd_t    cmd;
  bda_status_t status;

  bda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  bda_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .value       (in_chan.value),
    .wide_mode   (in_chan.wide_mode),
    .cmd         (cmd),
    .status      (status),
    .ascii_digit (out_chan.ascii_digit),
    .last_digit  (out_chan.last_digit)
  );

endmodule

>>> rtl/bda_checker.sv
// Port-level checks for binary_to_decimal_ascii, attached with a bind.
// Depends on bda_pkg and the top level's interface ports.
module bda_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input bda_pkg::ascii_t out_ascii,
  input logic            out_last
);
  import bda_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ascii) && $stable(out_last))
    else $error("result changed while stalled");

  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result dropped without being taken");

  // one request in flight: after taking one, the input side closes
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while converting");

  a_ascii_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ascii >= ASCII_ZERO) && (out_ascii <= ASCII_ZERO + 6'd9))
    else $error("result is not a decimal digit");

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_ascii (out_chan.ascii_digit),
  .out_last  (out_chan.last_digit)
);

>>> verif/decimal_ascii_monitor.sv
// Watches both channels of the binary to decimal ASCII converter, predicts the
// digit characters of each accepted request and compares them in order.
// Depends on bda_pkg and the bda_in_if / bda_out_if channel interfaces.
module decimal_ascii_monitor (
  input  logic clk,
  input  logic rst_n,
  bda_in_if    in_chan,
  bda_out_if   out_chan,
  output int   fail_count,
  output int   pending_digits,
  output int   values_seen,
  output int   digits_seen
);
  import bda_pkg::*;

  typedef struct packed {
    ascii_t ch;
    logic   last;
  } digit_char_t;

  localparam int unsigned DecadeStep [5] = '{10000, 1000, 100, 10, 1};

  digit_char_t expected_digits [$];

  initial begin
    fail_count     = 0;
    pending_digits = 0;
    values_seen    = 0;
    digits_seen    = 0;
  end

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("[%0t] digit mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    fail_count++;
  endtask

  // Repeated subtraction per decade; leading zeros dropped, ones always shown.
  function automatic void predict_digits(input value_t v, input logic wide);
    int unsigned rem;
    int unsigned d;
    bit          shown;
    digit_char_t e;
    rem   = wide ? int'(v) : int'(v[7:0]);
    shown = 1'b0;
    for (int p = (wide ? int'(POS_WIDE_FIRST) : int'(POS_NARROW_FIRST)); p <= int'(POS_ONES);
         p++) begin
      d = 0;
      while (rem >= DecadeStep[p] && d < 15) begin
        rem -= DecadeStep[p];
        d++;
      end
      if (d != 0 || shown || p == int'(POS_ONES)) begin
        shown  = 1'b1;
        e.ch   = ascii_t'(int'(ASCII_ZERO) + d);
        e.last = (p == int'(POS_ONES));
        expected_digits.push_back(e);
      end
    end
  endfunction

  always @(posedge clk) begin
    digit_char_t e;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        digits_seen++;
        if (expected_digits.size() == 0) begin
          report_mismatch("unexpected digit", -1, int'(out_chan.ascii_digit));
        end else begin
          e = expected_digits.pop_front();
          if (out_chan.ascii_digit !== e.ch)
            report_mismatch("ascii_digit", int'(e.ch), int'(out_chan.ascii_digit));
          if (out_chan.last_digit !== e.last)
            report_mismatch("last_digit", int'(e.last), int'(out_chan.last_digit));
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        predict_digits(in_chan.value, in_chan.wide_mode);
        values_seen++;
      end
      pending_digits = expected_digits.size();
    end
  end

endmodule

>>> verif/binary_to_decimal_ascii_tb.sv
// Top of the converter testbench: clock, reset, request and result drivers,
// watchdog and verdict. Depends on bda_pkg, the channel interfaces, the
// converter RTL and decimal_ascii_monitor.
module binary_to_decimal_ascii_tb;
  import bda_pkg::*;

  localparam int RandomValues = 78;
  localparam int HoldCycles   = 64;
  localparam int QuietLimit   = 2000;
  localparam int DrainCycles  = 48;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_digits;
  int   values_seen;
  int   digits_seen;
  int   quiet_cycles;
  bit   idle_on;
  bit   hold_request;

  bda_in_if  in_chan ();
  bda_out_if out_chan ();

  binary_to_decimal_ascii dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  decimal_ascii_monitor monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_chan       (in_chan),
    .out_chan      (out_chan),
    .fail_count    (fail_count),
    .pending_digits(pending_digits),
    .values_seen   (values_seen),
    .digits_seen   (digits_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.value      = '0;
    in_chan.wide_mode  = 1'b0;
    out_chan.ready     = 1'b0;
    idle_on            = 1'b1;
    hold_request       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_value(input value_t v, input logic wide);
    while (idle_on && $urandom_range(0, 99) < 11) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid     = 1'b1;
    in_chan.value     = v;
    in_chan.wide_mode = wide;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request   = 1'b0;
        out_chan.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      out_chan.ready = !(idle_on && $urandom_range(0, 99) < 11);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    quiet_cycles = 0;
    @(posedge rst_n);
    while (quiet_cycles < QuietLimit) @(posedge clk);
    $display("Watchdog: no channel activity for %0d cycles", QuietLimit);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    value_t v;
    logic   w;
    @(posedge rst_n);
    @(negedge clk);

    // zero, extremes, narrow mode with high byte set, decade edges, interior zeros
    send_value(16'd0,     1'b0);
    send_value(16'd0,     1'b1);
    send_value(16'd255,   1'b0);
    send_value(16'd65535, 1'b1);
    send_value(16'hFFFF,  1'b0);
    send_value(16'hFF00,  1'b0);
    send_value(16'h1234,  1'b0);
    send_value(16'd9,     1'b1);
    send_value(16'd10,    1'b1);
    send_value(16'd99,    1'b0);
    send_value(16'd100,   1'b0);
    send_value(16'd101,   1'b0);
    send_value(16'd200,   1'b0);
    send_value(16'd1,     1'b1);
    send_value(16'd999,   1'b1);
    send_value(16'd1000,  1'b1);
    send_value(16'd9999,  1'b1);
    send_value(16'd10000, 1'b1);
    send_value(16'd10001, 1'b1);
    send_value(16'd60000, 1'b1);
    send_value(16'd65530, 1'b1);
    send_value(16'd5,     1'b0);

    for (int i = 0; i < RandomValues; i++) begin
      if (i == 30) hold_request = 1'b1;
      if (i == 50) begin
        in_chan.valid = 1'b0;
        wait (pending_digits == 0);
        @(negedge clk);
      end
      if (i == 55) idle_on = 1'b0;
      if (i == 75) idle_on = 1'b1;
      if ($urandom_range(0, 3) == 0)
        v = value_t'($urandom_range(0, 300));
      else
        v = value_t'($urandom);
      w = 1'($urandom_range(0, 1));
      send_value(v, w);
    end
    in_chan.valid = 1'b0;

    wait (pending_digits == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("Converted %0d values into %0d digit characters (narrow and wide, extremes,",
             values_seen, digits_seen);
    $display("long result hold-off, drained pause and random back-pressure on both sides)");
    if (fail_count == 0 && pending_digits == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
